// ===== hw/rtl/lfc_pkg.sv =====
package lfc_pkg;

  localparam int unsigned FracBitsDefault = 30;
  localparam logic signed [31:0] GainReset = 32'sd16777216;

  // magnitude bounds of intermediate terms, independent of the fraction width
  localparam int unsigned BdeW = 34;
  localparam int unsigned FqW  = 36;
  localparam int unsigned AccW = 36;
  localparam int unsigned RsW  = 68;

  typedef struct packed {
    logic signed [31:0]     br;
    logic signed [31:0]     bz;
    logic signed [FqW-1:0]  fqr;
    logic signed [FqW-1:0]  fqz;
    logic                   fault;
  } lfc_carry_t;

  // divide by 2^n, round to nearest, ties away from zero; n >= 1
  function automatic logic signed [RsW-1:0] rnd_shift(logic signed [RsW-1:0] v,
                                                      int unsigned n);
    logic [RsW-1:0] mag;
    logic [RsW-1:0] half;
    mag  = v[RsW-1] ? (~v + RsW'(1)) : v;
    half = RsW'(1) << (n - 1);
    mag  = (mag + half) >> n;
    return v[RsW-1] ? $signed(~mag + RsW'(1)) : $signed(mag);
  endfunction

endpackage

// ===== hw/rtl/lfc_front.sv =====
module lfc_front #(
  parameter int unsigned FRAC_BITS = lfc_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [31:0]        br_i,
  input  logic signed [31:0]        bz_i,
  input  logic signed [31:0]        er_i,
  input  logic signed [31:0]        ez_i,
  input  logic signed [31:0]        cb_i,
  output logic                      valid_o,
  output logic [2*FRAC_BITS:0]      rem_o,
  output lfc_pkg::lfc_carry_t       carry_o
);
  import lfc_pkg::*;

  localparam int unsigned F = FRAC_BITS;
  localparam logic [63:0] One2 = 64'(1) << (2 * F);

  function automatic logic [2*F:0] rem_w(logic [63:0] x);
    return x[2*F:0];
  endfunction

  logic [4:0] v_q;

  // stage 1: products
  logic signed [31:0] br1_q, bz1_q, er1_q, ez1_q;
  logic signed [63:0] brbr1_q, bzbz1_q, brer1_q, bzez1_q, bzcb1_q, brcb1_q;
  // stage 2: speed, b.E
  logic signed [31:0] br2_q, bz2_q, er2_q, ez2_q;
  logic signed [63:0] bzcb2_q, brcb2_q;
  logic signed [BdeW-1:0] bde2_q;
  logic [2*F:0] rem2_q, rem3_q, rem4_q, rem5_q;
  logic fault2_q, fault3_q, fault4_q, fault5_q;
  // stage 3: b times b.E
  logic signed [31:0] br3_q, bz3_q, er3_q, ez3_q;
  logic signed [63:0] bzcb3_q, brcb3_q;
  logic signed [65:0] brbde3_q, bzbde3_q;
  // stage 4: forces
  logic signed [31:0] br4_q, bz4_q;
  logic signed [65:0] fr4_q, fz4_q;
  // stage 5: forces in field units
  logic signed [31:0] br5_q, bz5_q;
  logic signed [FqW-1:0] fqr5_q, fqz5_q;

  logic [63:0] s_d;
  logic signed [RsW-1:0] bde_d, fqr_d, fqz_d;
  logic signed [65:0] fr_d, fz_d;

  assign s_d   = $unsigned(brbr1_q) + $unsigned(bzbz1_q);
  assign bde_d = rnd_shift(RsW'(brer1_q) + RsW'(bzez1_q), F);
  assign fr_d  = (66'(er3_q) <<< F) - 66'(bzcb3_q) - brbde3_q;
  assign fz_d  = (66'(ez3_q) <<< F) + 66'(brcb3_q) - bzbde3_q;
  assign fqr_d = rnd_shift(RsW'(fr4_q), F);
  assign fqz_d = rnd_shift(RsW'(fz4_q), F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    br1_q   <= br_i;
    bz1_q   <= bz_i;
    er1_q   <= er_i;
    ez1_q   <= ez_i;
    brbr1_q <= br_i * br_i;
    bzbz1_q <= bz_i * bz_i;
    brer1_q <= br_i * er_i;
    bzez1_q <= bz_i * ez_i;
    bzcb1_q <= bz_i * cb_i;
    brcb1_q <= br_i * cb_i;

    br2_q    <= br1_q;
    bz2_q    <= bz1_q;
    er2_q    <= er1_q;
    ez2_q    <= ez1_q;
    bzcb2_q  <= bzcb1_q;
    brcb2_q  <= brcb1_q;
    bde2_q   <= bde_d[BdeW-1:0];
    fault2_q <= s_d >= One2;
    rem2_q   <= rem_w(One2 - s_d);

    br3_q    <= br2_q;
    bz3_q    <= bz2_q;
    er3_q    <= er2_q;
    ez3_q    <= ez2_q;
    bzcb3_q  <= bzcb2_q;
    brcb3_q  <= brcb2_q;
    brbde3_q <= 66'(br2_q) * 66'(bde2_q);
    bzbde3_q <= 66'(bz2_q) * 66'(bde2_q);
    fault3_q <= fault2_q;
    rem3_q   <= rem2_q;

    br4_q    <= br3_q;
    bz4_q    <= bz3_q;
    fr4_q    <= fr_d;
    fz4_q    <= fz_d;
    fault4_q <= fault3_q;
    rem4_q   <= rem3_q;

    br5_q    <= br4_q;
    bz5_q    <= bz4_q;
    fqr5_q   <= fqr_d[FqW-1:0];
    fqz5_q   <= fqz_d[FqW-1:0];
    fault5_q <= fault4_q;
    rem5_q   <= rem4_q;
  end

  assign valid_o       = v_q[4];
  assign rem_o         = rem5_q;
  assign carry_o.br    = br5_q;
  assign carry_o.bz    = bz5_q;
  assign carry_o.fqr   = fqr5_q;
  assign carry_o.fqz   = fqz5_q;
  assign carry_o.fault = fault5_q;

endmodule

// ===== hw/rtl/lfc_sqrt.sv =====
module lfc_sqrt #(
  parameter int unsigned FRAC_BITS = lfc_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [2*FRAC_BITS:0]      rem_i,
  input  lfc_pkg::lfc_carry_t       carry_i,
  output logic                      valid_o,
  output logic [FRAC_BITS:0]        root_o,
  output lfc_pkg::lfc_carry_t       carry_o
);
  import lfc_pkg::*;

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned N = F + 1;
  localparam int unsigned W = 2 * F + 2;

  logic [N-1:0] v_q;
  logic [W-1:0] d_q [N];
  logic [W-1:0] r_q [N];
  lfc_carry_t   c_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] Bit = W'(1) << (2 * F - 2 * k);
    logic [W-1:0] d_in, r_in, trial;
    lfc_carry_t   c_in;
    if (k == 0) begin : g_first
      assign d_in = W'(rem_i);
      assign r_in = '0;
      assign c_in = carry_i;
    end else begin : g_next
      assign d_in = d_q[k-1];
      assign r_in = r_q[k-1];
      assign c_in = c_q[k-1];
    end
    assign trial = r_in + Bit;
    always_ff @(posedge clk_i) begin
      if (d_in >= trial) begin
        d_q[k] <= d_in - trial;
        r_q[k] <= (r_in >> 1) + Bit;
      end else begin
        d_q[k] <= d_in;
        r_q[k] <= r_in >> 1;
      end
      c_q[k] <= c_in;
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1][F:0];
  assign carry_o = c_q[N-1];

endmodule

// ===== hw/rtl/lfc_scale.sv =====
module lfc_scale #(
  parameter int unsigned FRAC_BITS = lfc_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [FRAC_BITS:0]        root_i,
  input  lfc_pkg::lfc_carry_t       carry_i,
  input  logic signed [31:0]        gain_i,
  output logic                      done_o,
  output logic signed [31:0]        dr_dt_o,
  output logic signed [31:0]        dz_dt_o,
  output logic signed [31:0]        dbeta_r_dt_o,
  output logic signed [31:0]        dbeta_z_dt_o,
  output logic                      speed_fault_o
);
  import lfc_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = FqW + F + 2;

  logic [3:0] v_q;
  lfc_carry_t c1_q, c2_q, c3_q;
  logic signed [PW-1:0] pr1_q, pz1_q;
  logic signed [AccW-1:0] ar2_q, az2_q;
  logic [63:0] mr3_q, mz3_q;
  logic nr3_q, nz3_q;

  logic signed [RsW-1:0] ar_d, az_d;
  logic [AccW-1:0] mar_d, maz_d;
  logic [31:0] mg_d;
  logic [67:0] mr_d, mz_d;
  logic signed [31:0] rr_d, rz_d;

  assign ar_d  = rnd_shift(RsW'(pr1_q), F);
  assign az_d  = rnd_shift(RsW'(pz1_q), F);
  assign mar_d = ar2_q[AccW-1] ? $unsigned(-ar2_q) : $unsigned(ar2_q);
  assign maz_d = az2_q[AccW-1] ? $unsigned(-az2_q) : $unsigned(az2_q);
  assign mg_d  = gain_i[31] ? $unsigned(-gain_i) : $unsigned(gain_i);
  assign mr_d  = 68'(mar_d) * 68'(mg_d);
  assign mz_d  = 68'(maz_d) * 68'(mg_d);

  function automatic logic signed [31:0] sat_rnd(logic [63:0] m, logic neg);
    logic [63:0] q;
    q = (m >> 24) + 64'(m[23]);
    if (neg) begin
      return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      return (q >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
  endfunction

  assign rr_d = sat_rnd(mr3_q, nr3_q);
  assign rz_d = sat_rnd(mz3_q, nz3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= carry_i;
    pr1_q <= PW'(carry_i.fqr) * $signed(PW'(root_i));
    pz1_q <= PW'(carry_i.fqz) * $signed(PW'(root_i));

    c2_q  <= c1_q;
    ar2_q <= ar_d[AccW-1:0];
    az2_q <= az_d[AccW-1:0];

    c3_q  <= c2_q;
    mr3_q <= mr_d[63:0];
    mz3_q <= mz_d[63:0];
    nr3_q <= ar2_q[AccW-1] != gain_i[31];
    nz3_q <= az2_q[AccW-1] != gain_i[31];

    dr_dt_o       <= c3_q.br;
    dz_dt_o       <= c3_q.bz;
    speed_fault_o <= c3_q.fault;
    dbeta_r_dt_o  <= c3_q.fault ? '0 : rr_d;
    dbeta_z_dt_o  <= c3_q.fault ? '0 : rz_d;
  end

  assign done_o = v_q[3];

endmodule

// ===== hw/rtl/lorentz_force_cylindrical_3d.sv =====
// channel   ports                                         handshake
// input     beta_r_i beta_z_i e_radial_i e_axial_i        start_i & !busy_o
//           cb_azimuthal_i
// result    dr_dt_o dz_dt_o dbeta_r_dt_o dbeta_z_dt_o     done_o, one cycle
//           speed_fault_o
// config    gain_wdata_i                                  gain_we_i
//
// One item per cycle; busy_o is always low.
// The pipeline has 5 front stages, one square-root stage per
// root bit (FRAC_BITS + 1) and 4 scaling stages.
// Reset clears the valid pipeline and loads the gain with 1.0.
// The receiver cannot stall; results are presented for one cycle.
module lorentz_force_cylindrical_3d #(
  parameter int unsigned FRAC_BITS = lfc_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] beta_r_i,
  input  logic signed [31:0] beta_z_i,
  input  logic signed [31:0] e_radial_i,
  input  logic signed [31:0] e_axial_i,
  input  logic signed [31:0] cb_azimuthal_i,
  input  logic               gain_we_i,
  input  logic signed [31:0] gain_wdata_i,
  output logic               done_o,
  output logic signed [31:0] dr_dt_o,
  output logic signed [31:0] dz_dt_o,
  output logic signed [31:0] dbeta_r_dt_o,
  output logic signed [31:0] dbeta_z_dt_o,
  output logic               speed_fault_o
);
  import lfc_pkg::*;

  logic signed [31:0] gain_q;
  logic front_valid, sqrt_valid;
  logic [2*FRAC_BITS:0] rem;
  logic [FRAC_BITS:0] root;
  lfc_carry_t front_carry, sqrt_carry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (gain_we_i) begin
      gain_q <= gain_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  lfc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .br_i    (beta_r_i),
    .bz_i    (beta_z_i),
    .er_i    (e_radial_i),
    .ez_i    (e_axial_i),
    .cb_i    (cb_azimuthal_i),
    .valid_o (front_valid),
    .rem_o   (rem),
    .carry_o (front_carry)
  );

  lfc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .rem_i   (rem),
    .carry_i (front_carry),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .carry_o (sqrt_carry)
  );

  lfc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sqrt_valid),
    .root_i        (root),
    .carry_i       (sqrt_carry),
    .gain_i        (gain_q),
    .done_o        (done_o),
    .dr_dt_o       (dr_dt_o),
    .dz_dt_o       (dz_dt_o),
    .dbeta_r_dt_o  (dbeta_r_dt_o),
    .dbeta_z_dt_o  (dbeta_z_dt_o),
    .speed_fault_o (speed_fault_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lfc_pkg::*;

  localparam int unsigned Frac = FracBitsDefault;
  localparam int unsigned Latency = Frac + 10;
  localparam int unsigned CycleLimit = 400000;
  localparam logic signed [31:0] SMax = 32'sh7fffffff;
  localparam logic signed [31:0] SMin = 32'sh80000000;
  localparam logic signed [31:0] BOne = 32'sd1 <<< Frac;

  typedef struct packed {
    logic signed [31:0] br;
    logic signed [31:0] bz;
    logic signed [31:0] er;
    logic signed [31:0] ez;
    logic signed [31:0] cb;
  } force_item_t;

  typedef struct packed {
    logic signed [31:0] dr;
    logic signed [31:0] dz;
    logic signed [31:0] ar;
    logic signed [31:0] az;
    logic               fault;
  } deriv_t;

  typedef struct packed {
    force_item_t item;
    logic        known;
    deriv_t      res;
  } table_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] beta_r_i;
  logic signed [31:0] beta_z_i;
  logic signed [31:0] e_radial_i;
  logic signed [31:0] e_axial_i;
  logic signed [31:0] cb_azimuthal_i;
  logic               gain_we_i;
  logic signed [31:0] gain_wdata_i;
  logic               done_o;
  logic signed [31:0] dr_dt_o;
  logic signed [31:0] dz_dt_o;
  logic signed [31:0] dbeta_r_dt_o;
  logic signed [31:0] dbeta_z_dt_o;
  logic               speed_fault_o;

  lorentz_force_cylindrical_3d #(
    .FRAC_BITS(Frac)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .beta_r_i      (beta_r_i),
    .beta_z_i      (beta_z_i),
    .e_radial_i    (e_radial_i),
    .e_axial_i     (e_axial_i),
    .cb_azimuthal_i(cb_azimuthal_i),
    .gain_we_i     (gain_we_i),
    .gain_wdata_i  (gain_wdata_i),
    .done_o        (done_o),
    .dr_dt_o       (dr_dt_o),
    .dz_dt_o       (dz_dt_o),
    .dbeta_r_dt_o  (dbeta_r_dt_o),
    .dbeta_z_dt_o  (dbeta_z_dt_o),
    .speed_fault_o (speed_fault_o)
  );

  logic signed [31:0] gain_model;
  deriv_t             pending_derivs[$];
  int unsigned        errors;
  int unsigned        cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [127:0] round_div(logic signed [127:0] v, int unsigned n);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    m = (m + (128'd1 << (n - 1))) >> n;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] d);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > d) b = b >> 2;
    while (b != 0) begin
      if (d >= res + b) begin
        d = d - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] scaled_accel(logic signed [127:0] f,
                                                      logic signed [127:0] invg);
    logic signed [127:0] fq;
    logic signed [127:0] a;
    logic signed [127:0] g;
    logic [127:0]        m;
    logic                neg;
    g   = gain_model;
    fq  = round_div(f, Frac);
    a   = round_div(fq * invg, Frac);
    neg = (a < 0) != (g < 0);
    m   = (a < 0 ? -a : a) * (g < 0 ? -g : g);
    m   = (m >> 24) + ((m >> 23) & 128'd1);
    if (neg) return m >= 128'h80000000 ? SMin : -$signed(m[31:0]);
    return m >= 128'h7fffffff ? SMax : $signed(m[31:0]);
  endfunction

  function automatic deriv_t lorentz_derivs(force_item_t it);
    deriv_t              d;
    logic signed [127:0] br, bz, er, ez, cb, s, one2, invg, bde, fr, fz;
    br = it.br; bz = it.bz; er = it.er; ez = it.ez; cb = it.cb;
    one2 = 128'sd1 <<< (2 * Frac);
    s = br * br + bz * bz;
    d.dr = it.br;
    d.dz = it.bz;
    if (s >= one2) begin
      d.ar = 0;
      d.az = 0;
      d.fault = 1'b1;
    end else begin
      invg = $signed({64'd0, root_floor(64'(one2 - s))});
      bde  = round_div(br * er + bz * ez, Frac);
      fr   = (er <<< Frac) - bz * cb - br * bde;
      fz   = (ez <<< Frac) + br * cb - bz * bde;
      d.ar = scaled_accel(fr, invg);
      d.az = scaled_accel(fz, invg);
      d.fault = 1'b0;
    end
    return d;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    deriv_t w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_derivs.size() == 0) begin
        report("unexpected result", dr_dt_o, 0);
      end else begin
        w = pending_derivs.pop_front();
        if (dr_dt_o !== w.dr) report("dr_dt", dr_dt_o, w.dr);
        if (dz_dt_o !== w.dz) report("dz_dt", dz_dt_o, w.dz);
        if (dbeta_r_dt_o !== w.ar) report("dbeta_r_dt", dbeta_r_dt_o, w.ar);
        if (dbeta_z_dt_o !== w.az) report("dbeta_z_dt", dbeta_z_dt_o, w.az);
        if (speed_fault_o !== w.fault) report("speed_fault", speed_fault_o, w.fault);
      end
    end
  end

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(force_item_t it, logic known, deriv_t res);
    beta_r_i       = it.br;
    beta_z_i       = it.bz;
    e_radial_i     = it.er;
    e_axial_i      = it.ez;
    cb_azimuthal_i = it.cb;
    start_i        = 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_derivs.push_back(known ? res : lorentz_derivs(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pending_derivs.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  task automatic write_gain(logic signed [31:0] g);
    gain_we_i    = 1'b1;
    gain_wdata_i = g;
    @(negedge clk_i);
    gain_we_i    = 1'b0;
    gain_model   = g;
  endtask

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return SMax;
      1: return SMin;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rand_beta();
    logic signed [31:0] b;
    case ($urandom_range(0, 9))
      0: b = $signed($urandom());
      1: b = BOne - $signed($urandom_range(0, 64));
      2: b = $signed($urandom_range(0, 1 << 16));
      default: b = $signed($urandom_range(0, BOne - 1));
    endcase
    return $urandom_range(0, 1) ? -b : b;
  endfunction

  task automatic random_phase(int unsigned n);
    force_item_t it;
    deriv_t      dummy;
    int unsigned burst;
    dummy = '0;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        it.br = rand_beta();
        it.bz = rand_beta();
        it.er = rand_field();
        it.ez = rand_field();
        it.cb = rand_field();
        send_item(it, 1'b0, dummy);
        burst--;
        n--;
      end
      start_i = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  table_row_t rows[$];

  initial begin
    deriv_t flt;
    errors = 0;
    cycles = 0;
    gain_model = GainReset;
    rst_ni = 1'b0;
    start_i = 1'b0;
    gain_we_i = 1'b0;
    gain_wdata_i = '0;
    beta_r_i = '0;
    beta_z_i = '0;
    e_radial_i = '0;
    e_axial_i = '0;
    cb_azimuthal_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    flt = '{dr: 0, dz: 0, ar: 0, az: 0, fault: 1'b1};
    rows.push_back('{item: '{0, 0, 0, 0, 0}, known: 1, res: '{0, 0, 0, 0, 0}});
    rows.push_back('{item: '{0, 0, SMax, SMin, SMax}, known: 1,
                     res: '{0, 0, SMax, SMin, 0}});
    rows.push_back('{item: '{0, 0, -5, 7, SMin}, known: 1, res: '{0, 0, -5, 7, 0}});
    rows.push_back('{item: '{BOne, 0, 1, 2, 3}, known: 1, res: '{BOne, 0, 0, 0, 1}});
    rows.push_back('{item: '{-BOne, 0, SMax, 2, 3}, known: 1, res: '{-BOne, 0, 0, 0, 1}});
    rows.push_back('{item: '{0, BOne, 1, SMin, 3}, known: 1, res: '{0, BOne, 0, 0, 1}});
    rows.push_back('{item: '{0, -BOne, 1, 2, SMax}, known: 1, res: '{0, -BOne, 0, 0, 1}});
    rows.push_back('{item: '{SMax, SMax, 1, 2, 3}, known: 1, res: '{SMax, SMax, 0, 0, 1}});
    rows.push_back('{item: '{SMin, SMin, 1, 2, 3}, known: 1, res: '{SMin, SMin, 0, 0, 1}});
    rows.push_back('{item: '{0, SMin, 9, 9, 9}, known: 1, res: '{0, SMin, 0, 0, 1}});
    rows.push_back('{item: '{BOne / 2 + 32'sd200000000, BOne / 2 + 32'sd200000000, 1, 1, 1},
                     known: 0, res: flt});
    rows.push_back('{item: '{BOne / 2, BOne / 2, SMax, SMax, SMax}, known: 0, res: flt});
    rows.push_back('{item: '{BOne - 1, 0, SMin, SMax, SMin}, known: 0, res: flt});
    rows.push_back('{item: '{0, -(BOne - 1), SMax, SMin, SMax}, known: 0, res: flt});
    rows.push_back('{item: '{-(BOne / 2), BOne / 3, SMin, SMin, SMin}, known: 0, res: flt});
    rows.push_back('{item: '{BOne / 5, -(BOne / 7), 123456, -654321, 99999}, known: 0,
                     res: flt});
    rows.push_back('{item: '{-1, 1, SMax, SMax, SMin}, known: 0, res: flt});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);
    drain();

    random_phase(250);
    drain();
    write_gain(SMin);
    random_phase(150);
    drain();
    write_gain(SMax);
    random_phase(150);
    drain();
    write_gain(0);
    random_phase(50);
    drain();
    write_gain(-32'sd16777216);
    random_phase(150);
    drain();
    write_gain($signed($urandom()));
    random_phase(150);
    drain();
    write_gain(GainReset);
    random_phase(100);
    drain();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lfc_pkg.sv
hw/rtl/lfc_front.sv
hw/rtl/lfc_sqrt.sv
hw/rtl/lfc_scale.sv
hw/rtl/lorentz_force_cylindrical_3d.sv
tb/tb.sv
